### src/word_frequency_counter_unit_macros.svh
// Assertion macros for the word frequency counter.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef WORD_FREQUENCY_COUNTER_UNIT_MACROS_SVH
`define WORD_FREQUENCY_COUNTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WFC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("word frequency counter check failed");
`define WFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("word frequency counter check failed");
`else
`define WFC_ASSERT_SAME(label, ante, cons)
`define WFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/wfc_pkg.sv
// Shared types, codes and helpers of the word frequency counter.
// No dependencies.
`default_nettype none
package wfc_pkg;
	localparam int DEF_MAX_ENTRIES    = 64;
	localparam int DEF_MAX_WORD_CHARS = 32;
	localparam int DEF_COUNT_BITS     = 16;

	localparam logic [1:0] MODE_TEXT   = 2'd0;
	localparam logic [1:0] MODE_FLUSH  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [7:0] CH_DIGIT_LO = 8'd48;
	localparam logic [7:0] CH_DIGIT_HI = 8'd57;
	localparam logic [7:0] CH_UPPER_LO = 8'd65;
	localparam logic [7:0] CH_UPPER_HI = 8'd90;
	localparam logic [7:0] CH_LOWER_LO = 8'd97;
	localparam logic [7:0] CH_LOWER_HI = 8'd122;
	localparam logic [7:0] CH_CASE_GAP = 8'd32;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] text_byte;
		logic [5:0] entry_select;
		logic [4:0] char_position;
	} wfc_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [5:0]  entry_index;
		logic [15:0] word_count;
		logic        newly_inserted;
		logic        table_full_drop;
		logic        entry_valid;
		logic [5:0]  entry_length;
		logic [7:0]  entry_char;
	} wfc_result_t;

	function automatic logic is_token(input logic [7:0] b);
		is_token = (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) ||
			(b >= CH_UPPER_LO && b <= CH_UPPER_HI) ||
			(b >= CH_LOWER_LO && b <= CH_LOWER_HI);
	endfunction

	function automatic logic [7:0] fold_lower(input logic [7:0] b);
		fold_lower = (b >= CH_UPPER_LO && b <= CH_UPPER_HI) ? b + CH_CASE_GAP : b;
	endfunction
endpackage
`default_nettype wire

### src/wfc_if.sv
// Valid/ready channels of the word frequency counter.
// Depends on wfc_pkg.
`default_nettype none
interface wfc_item_if import wfc_pkg::*;;
	logic      valid;
	logic      ready;
	wfc_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface wfc_result_if import wfc_pkg::*;;
	logic        valid;
	logic        ready;
	wfc_result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### src/wfc_store.sv
// Word table storage: character memory and per-entry length/count memory.
// Depends on wfc_pkg for its parameter defaults; both reads are registered.
`default_nettype none
module wfc_store import wfc_pkg::*; #(
	parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
	parameter int MAX_WORD_CHARS = DEF_MAX_WORD_CHARS,
	parameter int COUNT_BITS     = DEF_COUNT_BITS,
	localparam int EW  = $clog2(MAX_ENTRIES),
	localparam int LW  = $clog2(MAX_WORD_CHARS + 1),
	localparam int WAW = $clog2(MAX_ENTRIES * MAX_WORD_CHARS),
	localparam int MW  = LW + COUNT_BITS
) (
	input  wire logic           clk,
	input  wire logic           char_we,
	input  wire logic [WAW-1:0] char_waddr,
	input  wire logic [7:0]     char_wdata,
	input  wire logic [WAW-1:0] char_raddr,
	output logic      [7:0]     char_rdata,
	input  wire logic           meta_we,
	input  wire logic [EW-1:0]  meta_waddr,
	input  wire logic [MW-1:0]  meta_wdata,
	input  wire logic           meta_re,
	input  wire logic [EW-1:0]  meta_raddr,
	output logic      [MW-1:0]  meta_rdata
);
	logic [7:0]    char_mem [MAX_ENTRIES * MAX_WORD_CHARS];
	logic [MW-1:0] meta_mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (char_we) begin
			char_mem[char_waddr] <= char_wdata;
		end
		char_rdata <= char_mem[char_raddr];
	end

	// hold the entry data between reads so the updater can use it
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		if (meta_re) begin
			meta_rdata <= meta_mem[meta_raddr];
		end
	end
endmodule
`default_nettype wire

### src/word_frequency_counter_unit.sv
// Word frequency counter. Takes text one byte per word on the item channel and
// counts how often each word (a run of 0-9, A-Z, a-z, folded to lower case) appears.
// A text byte that continues a word is taken and gives no result; at most
// MAX_WORD_CHARS characters are kept, further ones are dropped. A separator
// byte or a flush ends the word and starts a linear search of the table
// through one shared compare unit: each stored entry is read and its length
// checked, and on entries of equal length each character is read and compared.
// A hit updates the saturating count in place; a miss copies the word into the
// next free entry at one character per cycle (the single write port of the
// character memory), or flags a drop if the table is full. An empty word or
// mode 3 gives no result. The block is not ready while it searches; the result
// register lets the next item in while an earlier result still waits to be taken.
// Memories need no clearing pass: data of entries beyond the fill count is never used.
`default_nettype none
`include "word_frequency_counter_unit_macros.svh"
module word_frequency_counter_unit import wfc_pkg::*; #(
	parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
	parameter int MAX_WORD_CHARS = DEF_MAX_WORD_CHARS,
	parameter int COUNT_BITS     = DEF_COUNT_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	wfc_item_if.sink     item,
	wfc_result_if.source result
);
	localparam int EW  = $clog2(MAX_ENTRIES);
	localparam int UW  = $clog2(MAX_ENTRIES + 1);
	localparam int LW  = $clog2(MAX_WORD_CHARS + 1);
	localparam int JW  = $clog2(MAX_WORD_CHARS);
	localparam int WAW = $clog2(MAX_ENTRIES * MAX_WORD_CHARS);
	localparam int MW  = LW + COUNT_BITS;
	localparam logic [WAW-1:0] MWC_W = WAW'(MAX_WORD_CHARS);
	localparam logic [UW-1:0]  FULL  = UW'(MAX_ENTRIES);
	localparam logic [LW-1:0]  MWC_L = LW'(MAX_WORD_CHARS);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_LOOK   = 8'b0000_0010,
		ST_LCHK   = 8'b0000_0100,
		ST_CRD    = 8'b0000_1000,
		ST_CCHK   = 8'b0001_0000,
		ST_INSERT = 8'b0010_0000,
		ST_RDANS  = 8'b0100_0000,
		ST_WAIT   = 8'b1000_0000
	} state_t;

	state_t      state_q;
	logic [LW-1:0] wlen_q;
	logic [7:0]  wbuf_q [MAX_WORD_CHARS];
	logic [UW-1:0] used_q;
	logic [UW-1:0] ent_q;
	logic [JW-1:0] pos_q;
	logic [5:0]  rd_sel_q;
	logic [4:0]  rd_pos_q;
	wfc_result_t pend_q;
	wfc_result_t out_q;
	logic        out_v_q;

	logic           char_we;
	logic [WAW-1:0] char_waddr;
	logic [WAW-1:0] char_raddr;
	logic [7:0]     char_rdata;
	logic           meta_we;
	logic [EW-1:0]  meta_waddr;
	logic [MW-1:0]  meta_wdata;
	logic           meta_re;
	logic [EW-1:0]  meta_raddr;
	logic [MW-1:0]  meta_rdata;

	wfc_item_t        it;
	logic             acc;
	logic [LW-1:0]    st_len;
	logic [COUNT_BITS-1:0] st_cnt;
	logic [COUNT_BITS-1:0] inc_cnt;
	logic             last_char;
	logic             char_match;
	logic             ends_word;

	assign it        = item.data;
	assign item.ready = (state_q == ST_IDLE);
	assign acc       = item.valid && item.ready;
	assign result.valid = out_v_q;
	assign result.data  = out_q;

	assign st_len     = meta_rdata[MW-1:COUNT_BITS];
	assign st_cnt     = meta_rdata[COUNT_BITS-1:0];
	assign inc_cnt    = (st_cnt == '1) ? st_cnt : st_cnt + 1'b1;
	assign last_char  = (32'(pos_q) + 1) == 32'(wlen_q);
	assign char_match = (char_rdata == wbuf_q[pos_q]);
	// a separator byte or a flush closes the word being collected
	assign ends_word  = (it.mode == MODE_FLUSH) ||
		(it.mode == MODE_TEXT && !is_token(it.text_byte));

	// Memory address selection: the idle state looks up a read item, the search
	// states walk the table, the insert state copies the buffer.
	always_comb begin
		meta_re    = 1'b0;
		meta_raddr = ent_q[EW-1:0];
		char_raddr = WAW'(ent_q[EW-1:0]) * MWC_W + WAW'(pos_q);
		if (state_q == ST_IDLE) begin
			meta_re    = acc && it.mode == MODE_READ;
			meta_raddr = EW'(it.entry_select);
			char_raddr = WAW'(EW'(it.entry_select)) * MWC_W + WAW'(it.char_position);
		end else if (state_q == ST_LOOK) begin
			meta_re = 1'b1;
		end
		char_we    = (state_q == ST_INSERT);
		char_waddr = WAW'(used_q[EW-1:0]) * MWC_W + WAW'(pos_q);
		meta_we    = 1'b0;
		meta_waddr = ent_q[EW-1:0];
		meta_wdata = {st_len, inc_cnt};
		if (state_q == ST_CCHK && char_match && last_char) begin
			meta_we = 1'b1;
		end else if (state_q == ST_INSERT && last_char) begin
			meta_we    = 1'b1;
			meta_waddr = used_q[EW-1:0];
			meta_wdata = {wlen_q, COUNT_BITS'(1)};
		end
	end

	wfc_store #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.MAX_WORD_CHARS(MAX_WORD_CHARS),
		.COUNT_BITS    (COUNT_BITS)
	) u_store (
		.clk       (clk),
		.char_we   (char_we),
		.char_waddr(char_waddr),
		.char_wdata(wbuf_q[pos_q]),
		.char_raddr(char_raddr),
		.char_rdata(char_rdata),
		.meta_we   (meta_we),
		.meta_waddr(meta_waddr),
		.meta_wdata(meta_wdata),
		.meta_re   (meta_re),
		.meta_raddr(meta_raddr),
		.meta_rdata(meta_rdata)
	);

	// Collect letters and digits; the buffer itself needs no reset.
	always_ff @(posedge clk) begin
		if (acc && it.mode == MODE_TEXT && is_token(it.text_byte) && wlen_q < MWC_L) begin
			wbuf_q[wlen_q[JW-1:0]] <= fold_lower(it.text_byte);
		end
	end

	// Payload registers of the search and the pending result.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_sel_q <= it.entry_select;
			rd_pos_q <= it.char_position;
		end
		case (state_q)
			ST_CCHK: begin
				if (char_match && last_char) begin
					pend_q <= '{KIND_COUNT, 6'(ent_q), 16'(inc_cnt), 1'b0, 1'b0,
						1'b0, 6'd0, 8'd0};
				end
			end
			ST_LOOK: begin
				if (ent_q >= used_q && used_q == FULL) begin
					pend_q <= '{KIND_COUNT, 6'd0, 16'd0, 1'b0, 1'b1, 1'b0, 6'd0, 8'd0};
				end
			end
			ST_INSERT: begin
				pend_q <= '{KIND_COUNT, 6'(used_q), 16'd1, 1'b1, 1'b0, 1'b0, 6'd0, 8'd0};
			end
			ST_RDANS: begin
				if (32'(rd_sel_q) < 32'(used_q) && 32'(rd_sel_q) < MAX_ENTRIES) begin
					pend_q <= '{KIND_READ, rd_sel_q, 16'(st_cnt), 1'b0, 1'b0, 1'b1,
						6'(st_len),
						(32'(rd_pos_q) < 32'(st_len) && 32'(rd_pos_q) < MAX_WORD_CHARS)
							? char_rdata : 8'd0};
				end else begin
					pend_q <= '{KIND_READ, rd_sel_q, 16'd0, 1'b0, 1'b0, 1'b0, 6'd0, 8'd0};
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_WAIT && (!out_v_q || result.ready)) begin
			out_q <= pend_q;
		end
	end

	// Sequencer: one compare per step, one entry at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wlen_q  <= '0;
			used_q  <= '0;
			ent_q   <= '0;
			pos_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			// load the output register from the pending result, else drop a taken word
			if (state_q == ST_WAIT && (!out_v_q || result.ready)) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (it.mode == MODE_READ) begin
							state_q <= ST_RDANS;
						end else if (it.mode == MODE_TEXT && is_token(it.text_byte)) begin
							if (wlen_q < MWC_L) begin
								wlen_q <= wlen_q + 1'b1;
							end
						end else if (ends_word && wlen_q != '0) begin
							ent_q   <= '0;
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					if (ent_q >= used_q) begin
						pos_q <= '0;
						if (used_q == FULL) begin
							wlen_q  <= '0;
							state_q <= ST_WAIT;
						end else begin
							state_q <= ST_INSERT;
						end
					end else begin
						state_q <= ST_LCHK;
					end
				end
				ST_LCHK: begin
					if (st_len == wlen_q) begin
						pos_q   <= '0;
						state_q <= ST_CRD;
					end else begin
						ent_q   <= ent_q + 1'b1;
						state_q <= ST_LOOK;
					end
				end
				ST_CRD: begin
					state_q <= ST_CCHK;
				end
				ST_CCHK: begin
					if (!char_match) begin
						ent_q   <= ent_q + 1'b1;
						state_q <= ST_LOOK;
					end else if (last_char) begin
						wlen_q  <= '0;
						state_q <= ST_WAIT;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= ST_CRD;
					end
				end
				ST_INSERT: begin
					if (last_char) begin
						used_q  <= used_q + 1'b1;
						wlen_q  <= '0;
						state_q <= ST_WAIT;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_RDANS: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					// hold the result until the output register is free
					if (!out_v_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`WFC_ASSERT_SAME(a_used_bound, 1'b1, used_q <= FULL)
	`WFC_ASSERT_SAME(a_wlen_bound, 1'b1, wlen_q <= MWC_L)
	`WFC_ASSERT_SAME(a_drop_when_full, state_q == ST_WAIT && pend_q.table_full_drop, used_q == FULL)
	`WFC_ASSERT_NEXT(a_wait_holds, state_q == ST_WAIT && out_v_q && !result.ready, state_q == ST_WAIT)
endmodule
`default_nettype wire

### sim/word_frequency_counter_unit_test.sv
// Self-checking testbench for the word frequency counter.
// Depends on wfc_pkg, the wfc item and result interfaces and word_frequency_counter_unit.
`default_nettype none
module word_frequency_counter_unit_test;
	import wfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENTRIES = DEF_MAX_ENTRIES;
	localparam int N_CHARS   = DEF_MAX_WORD_CHARS;
	localparam int COUNT_TOP = (1 << DEF_COUNT_BITS) - 1;
	localparam int VOCAB     = 96;

	logic clk;
	logic arst_n;

	wfc_item_if   item();
	wfc_result_if result();

	word_frequency_counter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source)
	);

	always #5 clk = ~clk;

	// Local copy of the counter state, kept in step with accepted words.
	logic [7:0]  collected [N_CHARS];
	int          collected_len;
	logic [7:0]  table_chars [N_ENTRIES][N_CHARS];
	int          table_lens [N_ENTRIES];
	int          table_counts [N_ENTRIES];
	int          entries_filled;

	wfc_result_t pending_results[$];
	int          error_count;
	int          words_sent;
	int          results_checked;
	int          drops_seen;
	int          saturations_seen;

	int          sender_idle_pct;
	int          receiver_stall_pct;

	// Close the collected word: look it up, bump or insert, or flag a drop.
	function automatic void close_word();
		wfc_result_t r;
		bit          hit;
		if (collected_len == 0)
			return;
		r = '0;
		r.result_kind = KIND_COUNT;
		hit = 0;
		for (int i = 0; i < entries_filled && !hit; i++) begin
			if (table_lens[i] == collected_len) begin
				hit = 1;
				for (int k = 0; k < collected_len; k++)
					if (table_chars[i][k] != collected[k])
						hit = 0;
				if (hit) begin
					if (table_counts[i] < COUNT_TOP)
						table_counts[i]++;
					else
						saturations_seen++;
					r.entry_index = i[5:0];
					r.word_count  = table_counts[i][15:0];
				end
			end
		end
		if (!hit) begin
			if (entries_filled < N_ENTRIES) begin
				for (int k = 0; k < collected_len; k++)
					table_chars[entries_filled][k] = collected[k];
				table_lens[entries_filled]   = collected_len;
				table_counts[entries_filled] = 1;
				r.entry_index    = entries_filled[5:0];
				r.word_count     = 16'd1;
				r.newly_inserted = 1'b1;
				entries_filled++;
			end else begin
				r.table_full_drop = 1'b1;
				drops_seen++;
			end
		end
		collected_len = 0;
		pending_results.push_back(r);
	endfunction

	// Work out what one accepted word does to the state and the result stream.
	function automatic void count_item(input wfc_item_t it);
		wfc_result_t r;
		int          sel;
		case (it.mode)
			MODE_TEXT: begin
				if (is_ascii_token(it.text_byte)) begin
					if (collected_len < N_CHARS) begin
						collected[collected_len] = lower_case(it.text_byte);
						collected_len++;
					end
				end else begin
					close_word();
				end
			end
			MODE_FLUSH: close_word();
			MODE_READ: begin
				r = '0;
				r.result_kind = KIND_READ;
				r.entry_index = it.entry_select;
				sel = it.entry_select;
				if (sel < entries_filled) begin
					r.entry_valid  = 1'b1;
					r.word_count   = table_counts[sel][15:0];
					r.entry_length = table_lens[sel][5:0];
					if (it.char_position < table_lens[sel])
						r.entry_char = table_chars[sel][it.char_position];
				end
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic bit is_ascii_token(input logic [7:0] b);
		return (b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90) ||
			(b >= 8'd97 && b <= 8'd122);
	endfunction

	function automatic logic [7:0] lower_case(input logic [7:0] b);
		return (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
	endfunction

	// Drive one word onto the item channel and hold it until it is taken.
	task automatic send_word(input logic [1:0] mode, input logic [7:0] text_byte,
			input logic [5:0] sel, input logic [4:0] pos);
		wfc_item_t it;
		it.mode = mode;
		it.text_byte = text_byte;
		it.entry_select = sel;
		it.char_position = pos;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			item.valid = 1'b0;
			item.data  = wfc_item_t'($urandom);
			@(negedge clk);
		end
		item.valid = 1'b1;
		item.data  = it;
		do
			@(posedge clk);
		while (!item.ready);
		count_item(it);
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(MODE_TEXT, b, 6'($urandom), 5'($urandom));
	endtask

	task automatic send_flush();
		send_word(MODE_FLUSH, 8'($urandom), 6'($urandom), 5'($urandom));
	endtask

	task automatic send_read(input logic [5:0] sel, input logic [4:0] pos);
		send_word(MODE_READ, 8'($urandom), sel, pos);
	endtask

	task automatic release_channel();
		@(negedge clk);
		item.valid = 1'b0;
	endtask

	// Receiver: stall at random, in proportion to the current phase.
	always @(negedge clk)
		result.ready = ($urandom_range(99) >= receiver_stall_pct);

	// Compare each taken result, field by field, with the oldest expectation.
	always @(posedge clk) begin
		wfc_result_t got;
		wfc_result_t want;
		if (arst_n && result.valid && result.ready) begin
			got = result.data;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.result_kind !== want.result_kind ||
						got.entry_index !== want.entry_index ||
						got.word_count !== want.word_count ||
						got.newly_inserted !== want.newly_inserted ||
						got.table_full_drop !== want.table_full_drop ||
						got.entry_valid !== want.entry_valid ||
						got.entry_length !== want.entry_length ||
						got.entry_char !== want.entry_char) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, got);
					error_count++;
				end
			end
		end
	end

	// Directed words: byte extremes, every class boundary, empty words,
	// an overlong word, the unused mode, and reads of every kind.
	task automatic test_directed();
		send_read(6'd0, 5'd0);                  // read of an empty table
		send_flush();                           // empty word
		send_byte(8'd0);                        // separator, no word pending
		send_byte(8'd48);
		send_byte(8'd57);
		send_byte(8'd65);
		send_byte(8'd90);
		send_byte(8'd97);
		send_byte(8'd122);
		send_read(6'd63, 5'd31);                // read mid-word leaves it intact
		send_byte(8'd47);                       // ends "09azaz"
		send_byte(8'd58);
		send_byte(8'd64);
		send_byte(8'd91);
		send_byte(8'd96);
		send_byte(8'd123);
		send_byte(8'd255);
		send_word(MODE_UNUSED, 8'd65, 6'd0, 5'd0);  // unused mode, ignored
		for (int k = 0; k < N_CHARS + 6; k++)   // overlong word
			send_byte(8'd65 + 8'(k % 26));
		send_flush();
		send_read(6'd1, 5'd31);
		send_read(6'd1, 5'd0);
		send_read(6'd0, 5'd5);
		send_read(6'd0, 5'd6);                  // position past the word
		release_channel();
	endtask

	// Repeat one single-letter word so its count climbs in place.
	task automatic test_repeat_count();
		for (int n = 0; n < 8; n++) begin
			send_byte(8'd81);
			send_flush();
		end
		send_read(6'd2, 5'd0);
		release_channel();
	endtask

	// Build a vocabulary word from its index, with random case.
	task automatic send_vocab_word(input int n);
		int         len;
		logic [7:0] c;
		len = (n % 17 == 3) ? N_CHARS + $urandom_range(1, 5) : 1 + (n % 6);
		for (int k = 0; k < len; k++) begin
			c = 8'((n * 7 + k * 13 + k * n) % 36);
			c = (c < 10) ? 8'd48 + c : 8'd97 + c - 8'd10;
			if (c >= 8'd97 && $urandom_range(1))
				c = c - 8'd32;
			send_byte(c);
		end
	endtask

	function automatic logic [7:0] separator();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (is_ascii_token(b));
		return b;
	endfunction

	// Mostly well-formed text from a vocabulary larger than the table,
	// mixed with reads, flushes, stray bytes and the unused mode.
	task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
		int start;
		int pick;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		start = words_sent;
		while (words_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_vocab_word($urandom_range(VOCAB - 1));
				if ($urandom_range(9) == 0)
					send_flush();
				else
					send_byte(separator());
			end else if (pick < 80) begin
				send_read(6'($urandom), 5'($urandom));
			end else if (pick < 95) begin
				send_byte(8'($urandom));
			end else if (pick < 98) begin
				send_flush();
			end else begin
				send_word(MODE_UNUSED, 8'($urandom), 6'($urandom), 5'($urandom));
			end
		end
		release_channel();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.data = '0;
		result.ready = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		collected_len = 0;
		entries_filled = 0;
		error_count = 0;
		words_sent = 0;
		results_checked = 0;
		drops_seen = 0;
		saturations_seen = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_repeat_count();
		test_random(0, 0, 160);
		test_random(84, 0, 160);
		test_random(0, 84, 160);
		test_random(21, 21, 160);

		// Drain: wait for every expectation, then allow for stray output.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("Sent %0d words, checked %0d results; %0d entries filled,",
			words_sent, results_checked, entries_filled);
		$display("%0d table-full drops and %0d saturated counts seen.",
			drops_seen, saturations_seen);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#100ms;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
